>>> sv/ldol_pkg.sv
// ----------------------------------------------------------------------------
// ldol_pkg
// Shared types and constants of the layered draw-order list.
// ----------------------------------------------------------------------------
package ldol_pkg;

  localparam int CAPACITY    = 32;
  localparam int HANDLE_BITS = 16;
  localparam int MAX_OUT     = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int TK_W  = $clog2(MAX_OUT + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RENDER = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DRAWN     = 3'd3,
    ST_NONE      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_e;

  typedef struct packed {
    logic                   visible;
    logic signed [15:0]     depth;
    logic [7:0]             layer;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic             load_req;
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             wsel_new;
    cnt_op_e          cnt_op;
    logic             pend_load;
    logic             emit;
    logic             emit_pend;
    status_e          emit_status;
    logic             emit_last;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
    logic             key_gt;
    logic             match;
    logic             rd_vis;
    logic             out_free;
  } sts_t;

endpackage

>>> sv/ldol_datapath.sv
// ----------------------------------------------------------------------------
// ldol_datapath
// Entry memory, key compare, entry count, pending render handle and the
// output register of the draw-order list.
// ----------------------------------------------------------------------------
module ldol_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ldol_pkg::entry_t  in_entry_i,
  input  ldol_pkg::cmd_t    cmd_i,
  output ldol_pkg::sts_t    sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [15:0]       out_handle_o,
  output logic [2:0]        out_status_o,
  output logic              out_last_o
);
  import ldol_pkg::*;

  entry_t                 mem [CAPACITY];
  entry_t                 req_q;
  entry_t                 rd_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [HANDLE_BITS-1:0] pend_q;
  logic                   out_valid_q, out_valid_d;
  logic [15:0]            out_handle_q;
  logic [2:0]             out_status_q;
  logic                   out_last_q;
  entry_t                 wdata;

  assign wdata = cmd_i.wsel_new ? req_q : rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.waddr] <= wdata;
    end
    if (cmd_i.re) begin
      rd_q <= mem[cmd_i.raddr];
    end
    if (cmd_i.load_req) begin
      req_q <= in_entry_i;
    end
    if (cmd_i.pend_load) begin
      pend_q <= rd_q.handle;
    end
    if (cmd_i.emit) begin
      out_handle_q <= cmd_i.emit_pend ? 16'(pend_q) : 16'd0;
      out_status_q <= cmd_i.emit_status;
      out_last_q   <= cmd_i.emit_last;
    end
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_INC: count_d = count_q + CNT_W'(1);
      CNT_DEC: count_d = count_q - CNT_W'(1);
      CNT_CLR: count_d = '0;
      default: count_d = count_q;
    endcase
  end

  always_comb begin
    priority if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.count    = count_q;
  assign sts_o.full     = (count_q == CNT_W'(CAPACITY));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.key_gt   = (rd_q.layer > req_q.layer) ||
                          ((rd_q.layer == req_q.layer) && (rd_q.depth > req_q.depth));
  assign sts_o.match    = (rd_q.handle == req_q.handle);
  assign sts_o.rd_vis   = rd_q.visible;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_handle_o = out_handle_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

>>> sv/ldol_ctrl.sv
// ----------------------------------------------------------------------------
// ldol_ctrl
// Draw-order list sequencer: walks stored entries one per cycle for insert,
// remove and render (render stalls on a held output); schedules every result.
// ----------------------------------------------------------------------------
module ldol_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ldol_pkg::op_e   op_i,
  input  ldol_pkg::sts_t  sts_i,
  output ldol_pkg::cmd_t  cmd_o
);
  import ldol_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INS  = 7'b0000010,
    S_PUT  = 7'b0000100,
    S_REM  = 7'b0001000,
    S_RND  = 7'b0010000,
    S_RFIN = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] ev_q, ev_d;
  logic             found_q, found_d;
  logic [TK_W-1:0]  tk_q, tk_d;
  status_e          res_q, res_d;
  logic             last_ent;
  logic             advance;

  assign last_ent = (CNT_W'(ev_q) == (sts_i.count - CNT_W'(1)));

  always_comb begin
    cmd_o             = '0;
    cmd_o.cnt_op      = CNT_HOLD;
    cmd_o.emit_status = ST_DONE;
    in_ready_o        = 1'b0;
    state_d           = state_q;
    ev_d              = ev_q;
    found_d           = found_q;
    tk_d              = tk_q;
    res_d             = res_q;
    advance           = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          unique case (op_i)
            OP_INSERT: begin
              priority if (sts_i.full) begin
                res_d   = ST_FULL;
                state_d = S_DONE;
              end else if (sts_i.empty) begin
                ev_d    = '0;
                state_d = S_PUT;
              end else begin
                cmd_o.re    = 1'b1;
                cmd_o.raddr = IDX_W'(sts_i.count - CNT_W'(1));
                ev_d        = IDX_W'(sts_i.count - CNT_W'(1));
                state_d     = S_INS;
              end
            end
            OP_REMOVE: begin
              if (sts_i.empty) begin
                res_d   = ST_NOT_FOUND;
                state_d = S_DONE;
              end else begin
                cmd_o.re    = 1'b1;
                cmd_o.raddr = '0;
                ev_d        = '0;
                found_d     = 1'b0;
                state_d     = S_REM;
              end
            end
            OP_CLEAR: begin
              cmd_o.cnt_op = CNT_CLR;
              res_d        = ST_DONE;
              state_d      = S_DONE;
            end
            default: begin
              if (sts_i.empty) begin
                res_d   = ST_NONE;
                state_d = S_DONE;
              end else begin
                cmd_o.re    = 1'b1;
                cmd_o.raddr = '0;
                ev_d        = '0;
                tk_d        = '0;
                state_d     = S_RND;
              end
            end
          endcase
        end
      end

      S_INS: begin
        if (sts_i.key_gt) begin
          cmd_o.we    = 1'b1;
          cmd_o.waddr = ev_q + IDX_W'(1);
          if (ev_q == '0) begin
            state_d = S_PUT;
          end else begin
            cmd_o.re    = 1'b1;
            cmd_o.raddr = ev_q - IDX_W'(1);
            ev_d        = ev_q - IDX_W'(1);
          end
        end else begin
          cmd_o.we       = 1'b1;
          cmd_o.waddr    = ev_q + IDX_W'(1);
          cmd_o.wsel_new = 1'b1;
          cmd_o.cnt_op   = CNT_INC;
          res_d          = ST_DONE;
          state_d        = S_DONE;
        end
      end

      S_PUT: begin
        cmd_o.we       = 1'b1;
        cmd_o.waddr    = ev_q;
        cmd_o.wsel_new = 1'b1;
        cmd_o.cnt_op   = CNT_INC;
        res_d          = ST_DONE;
        state_d        = S_DONE;
      end

      S_REM: begin
        if (found_q) begin
          cmd_o.we    = 1'b1;
          cmd_o.waddr = ev_q - IDX_W'(1);
        end else if (sts_i.match) begin
          found_d = 1'b1;
        end
        if (last_ent) begin
          if (found_q || sts_i.match) begin
            cmd_o.cnt_op = CNT_DEC;
            res_d        = ST_DONE;
          end else begin
            res_d = ST_NOT_FOUND;
          end
          state_d = S_DONE;
        end else begin
          cmd_o.re    = 1'b1;
          cmd_o.raddr = ev_q + IDX_W'(1);
          ev_d        = ev_q + IDX_W'(1);
        end
      end

      S_RND: begin
        if (sts_i.rd_vis) begin
          if ((tk_q != '0) && !sts_i.out_free) begin
            advance = 1'b0;
          end else begin
            if (tk_q != '0) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_pend   = 1'b1;
              cmd_o.emit_status = ST_DRAWN;
              cmd_o.emit_last   = 1'b0;
            end
            cmd_o.pend_load = 1'b1;
            tk_d            = tk_q + TK_W'(1);
          end
        end
        if (advance) begin
          if ((sts_i.rd_vis && (tk_q == TK_W'(MAX_OUT - 1))) || last_ent) begin
            state_d = S_RFIN;
          end else begin
            cmd_o.re    = 1'b1;
            cmd_o.raddr = ev_q + IDX_W'(1);
            ev_d        = ev_q + IDX_W'(1);
          end
        end
      end

      S_RFIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_pend   = (tk_q != '0);
          cmd_o.emit_status = (tk_q != '0) ? ST_DRAWN : ST_NONE;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end

      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_pend   = 1'b0;
          cmd_o.emit_status = res_q;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ev_q    <= '0;
      found_q <= 1'b0;
      tk_q    <= '0;
      res_q   <= ST_DONE;
    end else begin
      state_q <= state_d;
      ev_q    <= ev_d;
      found_q <= found_d;
      tk_q    <= tk_d;
      res_q   <= res_d;
    end
  end

endmodule

>>> sv/layered_draw_order_list.sv
// ----------------------------------------------------------------------------
// layered_draw_order_list
// Bounded display list kept sorted by layer, then depth order.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries commands: insert, remove by handle, clear, render.
//   One command is taken at a time; tready is high while the sequencer idles.
//   Insert, remove and clear return one transaction with tlast set.
//   Render returns one transaction per visible entry (at most 32), tlast on
//   the final one, or a single "nothing drawn" transaction.
//   Clear, a full insert and a remove or render on an empty list go straight
//   to the result. Insert steps back from the last entry through those with a
//   greater key, shifting each up; remove walks all stored entries; render
//   walks to the last entry or the 32nd visible one, stalling while the
//   receiver holds a result. One memory read port steps each walk.
//   A result waits in the master-side output register; while it waits the
//   next command is still accepted and a walk stalls only when it must emit.
//   Reset empties the list and drops any held result; the entry memory itself
//   is not cleared.
// ----------------------------------------------------------------------------
module layered_draw_order_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[1:0], handle[17:2], layer[25:18], depth_order[41:26], visible[42]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_handle[15:0], status[18:16]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import ldol_pkg::*;

  op_e         op;
  entry_t      in_entry;
  cmd_t        cmd;
  sts_t        sts;
  logic [15:0] out_handle;
  logic [2:0]  out_status;

  assign op               = op_e'(s_axis_tdata[1:0]);
  assign in_entry.handle  = HANDLE_BITS'(s_axis_tdata[17:2]);
  assign in_entry.layer   = s_axis_tdata[25:18];
  assign in_entry.depth   = s_axis_tdata[41:26];
  assign in_entry.visible = s_axis_tdata[42];

  ldol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (op),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ldol_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_entry_i   (in_entry),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_handle_o (out_handle),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_status, out_handle};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result emitted over a held result");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second command taken while one is in flight");

  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.cnt_op == CNT_INC) |-> (!sts.full && cmd.we && cmd.wsel_new))
    else $error("insert committed on a full list");

endmodule

>>> bench/draw_list_board_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// draw_list_board_pkg
// Scoreboard of the layered draw-order list bench: keeps its own sorted copy
// of the display list, predicts the response transactions of each accepted
// command and checks the returned transactions against them in order.
// ----------------------------------------------------------------------------
package draw_list_board_pkg;

  import ldol_pkg::*;

  localparam logic [15:0] HANDLE_MASK = 16'((32'd1 << HANDLE_BITS) - 1);

  typedef struct {
    logic [15:0]        handle;
    logic [7:0]         layer;
    logic signed [15:0] depth;
    logic               vis;
  } slot_t;

  typedef struct {
    logic [15:0] handle;
    status_e     status;
    logic        last;
  } draw_result_t;

  class draw_list_board;
    slot_t          slots[CAPACITY];
    int unsigned    fill;
    draw_result_t   awaited_q[$];
    int unsigned    errors;
    int unsigned    n_cmds;
    int unsigned    n_results;
    int unsigned    n_full;
    int unsigned    n_miss;
    int unsigned    n_none;
    int unsigned    max_drawn;

    function new();
      fill      = 0;
      errors    = 0;
      n_cmds    = 0;
      n_results = 0;
      n_full    = 0;
      n_miss    = 0;
      n_none    = 0;
      max_drawn = 0;
    endfunction

    function void queue_result(logic [15:0] h, status_e st, logic lst);
      draw_result_t r;
      r.handle = h;
      r.status = st;
      r.last   = lst;
      awaited_q.insert(awaited_q.size(), r);
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    function logic [15:0] pick_handle();
      if (fill == 0) return 16'($urandom_range(0, 65535));
      return slots[$urandom_range(0, fill - 1)].handle;
    endfunction

    function void note_command(op_e op, logic [15:0] h, logic [7:0] lay,
                               logic signed [15:0] dep, logic vis);
      int          pos;
      int          i;
      int          total;
      int          drawn;
      logic [15:0] hm;
      hm = h & HANDLE_MASK;
      n_cmds++;
      case (op)
        OP_INSERT: begin
          if (fill >= CAPACITY) begin
            n_full++;
            queue_result(16'd0, ST_FULL, 1'b1);
          end else begin
            pos = fill;
            for (i = 0; i < fill; i++) begin
              if (slots[i].layer > lay || (slots[i].layer == lay && slots[i].depth > dep)) begin
                pos = i;
                break;
              end
            end
            for (i = fill; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = '{hm, lay, dep, vis};
            fill++;
            queue_result(16'd0, ST_DONE, 1'b1);
          end
        end
        OP_REMOVE: begin
          pos = -1;
          for (i = 0; i < fill; i++) begin
            if (slots[i].handle == hm) begin
              pos = i;
              break;
            end
          end
          if (pos < 0) begin
            n_miss++;
            queue_result(16'd0, ST_NOT_FOUND, 1'b1);
          end else begin
            for (i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
            queue_result(16'd0, ST_DONE, 1'b1);
          end
        end
        OP_CLEAR: begin
          fill = 0;
          queue_result(16'd0, ST_DONE, 1'b1);
        end
        default: begin
          total = 0;
          for (i = 0; i < fill; i++) if (slots[i].vis && total < MAX_OUT) total++;
          if (total == 0) begin
            n_none++;
            queue_result(16'd0, ST_NONE, 1'b1);
          end else begin
            drawn = 0;
            for (i = 0; i < fill && drawn < total; i++) begin
              if (slots[i].vis) begin
                drawn++;
                queue_result(slots[i].handle, ST_DRAWN, drawn == total);
              end
            end
            if (total > max_drawn) max_drawn = total;
          end
        end
      endcase
    endfunction

    function void check_result(logic [23:0] data, logic tlast);
      draw_result_t want;
      n_results++;
      if (awaited_q.size() == 0) begin
        errors++;
        $error("unexpected transaction: out_handle %h status %0d last %b",
               data[15:0], data[18:16], tlast);
        return;
      end
      want = awaited_q.pop_front();
      if (data[15:0] !== want.handle) begin
        errors++;
        $error("out_handle mismatch: expected %h, actual %h", want.handle, data[15:0]);
      end
      if (data[18:16] !== want.status) begin
        errors++;
        $error("status mismatch: expected %0d, actual %0d", want.status, data[18:16]);
      end
      if (tlast !== want.last) begin
        errors++;
        $error("last mismatch: expected %b, actual %b", want.last, tlast);
      end
    endfunction
  endclass

endpackage

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench of the layered draw-order list: directed commands on the edge cases,
// then random command streams under changing idle patterns and a long output
// hold-off, with every response transaction checked by the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

  import ldol_pkg::*;
  import draw_list_board_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_data = '0;
  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned n_holds = 0;

  draw_list_board board;

  layered_draw_order_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_valid && s_axis_tready) begin
      board.note_command(op_e'(s_data[1:0]), s_data[17:2], s_data[25:18],
                         s_data[41:26], s_data[42]);
    end
    if (rst_ni && m_axis_tvalid && m_ready) begin
      board.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else begin
        m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_cmd(op_e op, logic [15:0] h, logic [7:0] lay,
                          logic signed [15:0] dep, logic vis);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {5'd0, vis, dep, lay, h, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_cmd(op_e op);
    logic [15:0]        h;
    logic [7:0]         lay;
    logic signed [15:0] dep;
    logic               vis;
    if (op == OP_REMOVE && $urandom_range(0, 99) < 65) h = board.pick_handle();
    else if ($urandom_range(0, 1) == 0) h = 16'($urandom_range(0, 15));
    else h = 16'($urandom_range(0, 65535));
    lay = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    dep = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 8) - 4)
                                       : 16'($urandom_range(0, 65535));
    vis = ($urandom_range(0, 99) < 75);
    send_cmd(op, h, lay, dep, vis);
  endtask

  task automatic run_phase(int unsigned src_pct, int unsigned snk_pct, bit with_hold);
    int unsigned r;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    send_random_cmd(OP_CLEAR);
    repeat (35) send_random_cmd(OP_INSERT);
    send_random_cmd(OP_RENDER);
    if (with_hold) begin
      hold_req = ~hold_req;
      n_holds++;
    end
    repeat (40) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_random_cmd(OP_INSERT);
      else if (r < 70) send_random_cmd(OP_REMOVE);
      else if (r < 93) send_random_cmd(OP_RENDER);
      else send_random_cmd(OP_CLEAR);
    end
    wait_drained();
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 38;
    snk_idle_pct = 56;
    send_cmd(OP_RENDER, 16'h0000, 8'd0, 16'sd0, 1'b1);
    send_cmd(OP_CLEAR, 16'h0000, 8'd0, 16'sd0, 1'b0);
    send_cmd(OP_REMOVE, 16'h1234, 8'd0, 16'sd0, 1'b0);
    send_cmd(OP_INSERT, 16'hFFFF, 8'd255, 16'sh7FFF, 1'b1);
    send_cmd(OP_INSERT, 16'h0000, 8'd0, 16'sh8000, 1'b1);
    send_cmd(OP_INSERT, 16'h00A5, 8'd7, 16'sd0, 1'b0);
    send_cmd(OP_INSERT, 16'h5A00, 8'd7, 16'sd0, 1'b1);
    send_cmd(OP_INSERT, 16'h0101, 8'd7, -16'sd1, 1'b1);
    send_cmd(OP_INSERT, 16'h0202, 8'd255, 16'sh7FFF, 1'b1);
    send_cmd(OP_INSERT, 16'h0303, 8'd0, 16'sh8000, 1'b0);
    send_cmd(OP_RENDER, 16'h0000, 8'd0, 16'sd0, 1'b0);
    send_cmd(OP_INSERT, 16'h5A00, 8'd0, 16'sd5, 1'b1);
    send_cmd(OP_REMOVE, 16'h5A00, 8'd0, 16'sd0, 1'b0);
    send_cmd(OP_RENDER, 16'h0000, 8'd0, 16'sd0, 1'b0);
    send_cmd(OP_REMOVE, 16'hBEEF, 8'd0, 16'sd0, 1'b0);
    send_cmd(OP_REMOVE, 16'hFFFF, 8'd0, 16'sd0, 1'b0);
    send_cmd(OP_RENDER, 16'h0000, 8'd0, 16'sd0, 1'b0);
    send_cmd(OP_CLEAR, 16'h0000, 8'd0, 16'sd0, 1'b0);
    send_cmd(OP_INSERT, 16'h0F0F, 8'd3, 16'sd3, 1'b0);
    send_cmd(OP_RENDER, 16'h0000, 8'd0, 16'sd0, 1'b0);
    send_cmd(OP_REMOVE, 16'h0F0F, 8'd0, 16'sd0, 1'b0);
    send_cmd(OP_REMOVE, 16'h0F0F, 8'd0, 16'sd0, 1'b0);
    wait_drained();

    run_phase(38, 56, 1'b1);
    run_phase(56, 38, 1'b0);
    run_phase(0, 0, 1'b0);

    repeat (40) @(posedge clk_i);
    $display("covered %0d commands and %0d response transactions, longest render %0d",
             board.n_cmds, board.n_results, board.max_drawn);
    $display("full inserts %0d, absent removes %0d, empty renders %0d, output hold-offs %0d",
             board.n_full, board.n_miss, board.n_none, n_holds);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
